>>> rtl/knps_pkg.sv
// ----------------------------------------------------------------------------
// knps_pkg
// Shared types and constants of the k-nearest point select unit.
// ----------------------------------------------------------------------------
package knps_pkg;

	// configuration register widths and indexes
	localparam int LC_W      = 7;
	localparam int SC_W      = 4;
	localparam int CFG_W     = 7;
	localparam int CFG_IDX_W = 1;

	localparam logic [CFG_IDX_W-1:0] REG_LIGHT_COUNT  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_SHADOW_COUNT = 1'b1;

	localparam logic [LC_W-1:0] LIGHT_COUNT_RST  = 7'd64;
	localparam logic [SC_W-1:0] SHADOW_COUNT_RST = 4'd4;

	// input item kinds
	localparam logic CMD_LOAD  = 1'b0;
	localparam logic CMD_QUERY = 1'b1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_EMIT_RD,
		ST_EMIT_LD
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic mem_we;
		logic rd_en;
		logic rd_scan;
		logic scan_vld;
		logic cam_load;
		logic clear_best;
		logic pop_best;
		logic out_load;
		logic out_last;
	} knps_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic pipe_empty;
		logic out_free;
	} knps_sts_t;

endpackage

>>> rtl/knps_ctrl.sv
// ----------------------------------------------------------------------------
// knps_ctrl
// Sequencer: config registers, scan and emit counters, command generation.
// ----------------------------------------------------------------------------
module knps_ctrl #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_SELECT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               in_valid,
	output logic                               in_ready,
	input  logic                               in_cmd,
	input  logic                               cfg_we,
	input  logic [knps_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [knps_pkg::CFG_W-1:0]         cfg_wdata,
	input  knps_pkg::knps_sts_t                sts,
	output knps_pkg::knps_cmd_t                cmd,
	output logic [$clog2(MAX_POINTS)-1:0]      scan_addr,
	output logic [$clog2(MAX_SELECT+1)-1:0]    sel_count
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);
	localparam int SEL_W = $clog2(MAX_SELECT + 1);
	localparam int NW    = (CNT_W > knps_pkg::LC_W) ? CNT_W : knps_pkg::LC_W;
	localparam int KW0   = (CNT_W > knps_pkg::SC_W) ? CNT_W : knps_pkg::SC_W;
	localparam int KW    = (KW0 > SEL_W) ? KW0 : SEL_W;

	knps_pkg::state_t              state_q, state_d;
	logic [knps_pkg::LC_W-1:0]     light_count_q;
	logic [knps_pkg::SC_W-1:0]     shadow_count_q;
	logic [CNT_W-1:0]              n_q;
	logic [SEL_W-1:0]              k_q;
	logic [IDX_W-1:0]              scan_cnt_q;
	logic [SEL_W-1:0]              emit_cnt_q;

	logic [NW-1:0]                 lc_ext;
	logic [CNT_W-1:0]              n_c;
	logic [KW-1:0]                 k_t;
	logic [SEL_W-1:0]              k_c;
	logic                          accept;
	logic                          last_scan;
	logic                          last_emit;

	// participating count and result count for the next query
	always_comb begin
		lc_ext = NW'(light_count_q);
		if (lc_ext > NW'(MAX_POINTS)) begin
			n_c = CNT_W'(MAX_POINTS);
		end else begin
			n_c = lc_ext[CNT_W-1:0];
		end
		k_t = KW'(shadow_count_q);
		if (k_t > KW'(n_c)) begin
			k_t = KW'(n_c);
		end
		if (k_t > KW'(MAX_SELECT)) begin
			k_t = KW'(MAX_SELECT);
		end
		k_c = k_t[SEL_W-1:0];
	end

	assign accept    = in_valid && in_ready;
	assign last_scan = (CNT_W'(scan_cnt_q) == (n_q - CNT_W'(1)));
	assign last_emit = (emit_cnt_q == (k_q - SEL_W'(1)));
	assign scan_addr = scan_cnt_q;
	assign sel_count = k_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			light_count_q  <= knps_pkg::LIGHT_COUNT_RST;
			shadow_count_q <= knps_pkg::SHADOW_COUNT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				knps_pkg::REG_LIGHT_COUNT:  light_count_q  <= cfg_wdata;
				knps_pkg::REG_SHADOW_COUNT: shadow_count_q <= cfg_wdata[knps_pkg::SC_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= knps_pkg::ST_IDLE;
			n_q        <= '0;
			k_q        <= '0;
			scan_cnt_q <= '0;
			emit_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == knps_pkg::ST_IDLE && accept && in_cmd == knps_pkg::CMD_QUERY) begin
				n_q        <= n_c;
				k_q        <= k_c;
				scan_cnt_q <= '0;
			end
			if (state_q == knps_pkg::ST_SCAN) begin
				scan_cnt_q <= scan_cnt_q + IDX_W'(1);
			end
			if (state_q == knps_pkg::ST_DRAIN) begin
				emit_cnt_q <= '0;
			end
			if (state_q == knps_pkg::ST_EMIT_LD && sts.out_free) begin
				emit_cnt_q <= emit_cnt_q + SEL_W'(1);
			end
		end
	end

	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		in_ready = 1'b0;
		unique case (state_q)
			knps_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (accept) begin
					if (in_cmd == knps_pkg::CMD_LOAD) begin
						cmd.mem_we = 1'b1;
					end else begin
						cmd.cam_load   = 1'b1;
						cmd.clear_best = 1'b1;
						if (k_c != '0) begin
							state_d = knps_pkg::ST_SCAN;
						end
					end
				end
			end
			knps_pkg::ST_SCAN: begin
				cmd.rd_en    = 1'b1;
				cmd.rd_scan  = 1'b1;
				cmd.scan_vld = 1'b1;
				if (last_scan) begin
					state_d = knps_pkg::ST_DRAIN;
				end
			end
			knps_pkg::ST_DRAIN: begin
				if (sts.pipe_empty) begin
					state_d = knps_pkg::ST_EMIT_RD;
				end
			end
			knps_pkg::ST_EMIT_RD: begin
				cmd.rd_en = 1'b1;
				state_d   = knps_pkg::ST_EMIT_LD;
			end
			knps_pkg::ST_EMIT_LD: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					cmd.out_last = last_emit;
					cmd.pop_best = 1'b1;
					state_d      = last_emit ? knps_pkg::ST_IDLE : knps_pkg::ST_EMIT_RD;
				end
			end
			default: state_d = knps_pkg::ST_IDLE;
		endcase
	end

endmodule

>>> rtl/knps_dp.sv
// ----------------------------------------------------------------------------
// knps_dp
// Datapath: point memory, distance pipeline, sorted best list, output register.
// ----------------------------------------------------------------------------
module knps_dp #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_SELECT = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  knps_pkg::knps_cmd_t                cmd,
	output knps_pkg::knps_sts_t                sts,
	input  logic [$clog2(MAX_POINTS)-1:0]      scan_addr,
	input  logic [$clog2(MAX_SELECT+1)-1:0]    sel_count,
	input  logic [$clog2(MAX_POINTS)-1:0]      in_slot,
	input  logic [COORD_BITS-1:0]              in_x,
	input  logic [COORD_BITS-1:0]              in_y,
	input  logic [COORD_BITS-1:0]              in_z,
	input  logic                               out_ready,
	output logic                               out_valid,
	output logic [$clog2(MAX_POINTS)-1:0]      out_index,
	output logic [COORD_BITS-1:0]              out_x,
	output logic [COORD_BITS-1:0]              out_y,
	output logic [COORD_BITS-1:0]              out_z,
	output logic [2*COORD_BITS:0]              out_dist,
	output logic                               out_last
);

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int SEL_W  = $clog2(MAX_SELECT + 1);
	localparam int C      = COORD_BITS;
	localparam int DIST_W = 2 * COORD_BITS + 1;
	localparam int SQ_W   = 2 * COORD_BITS;

	logic [3*C-1:0]          mem_q [MAX_POINTS];
	logic [C-1:0]            cam_x_q;
	logic [C-1:0]            cam_z_q;

	logic [IDX_W-1:0]        rd_addr;
	logic                    wr_en;
	logic [3*C-1:0]          rd_data_s1;
	logic [IDX_W-1:0]        idx_s1, idx_s2, idx_s3;
	logic                    vld_s1, vld_s2, vld_s3;
	logic [SQ_W-1:0]         sqx_s2, sqz_s2;
	logic [DIST_W-1:0]       dist_s3;

	logic signed [C:0]       dx, dz;
	logic signed [2*C+1:0]   px, pz;

	logic [DIST_W-1:0]       best_dist_q [MAX_SELECT];
	logic [IDX_W-1:0]        best_idx_q  [MAX_SELECT];
	logic [MAX_SELECT-1:0]   best_vld_q;
	logic [MAX_SELECT-1:0]   lt;

	logic                    out_vld_q;
	logic                    out_last_q;
	logic [IDX_W-1:0]        out_idx_q;
	logic [3*C-1:0]          out_pt_q;
	logic [DIST_W-1:0]       out_dist_q;

	// loads beyond the table are dropped
	assign wr_en   = cmd.mem_we && ({1'b0, in_slot} < (IDX_W+1)'(MAX_POINTS));
	assign rd_addr = cmd.rd_scan ? scan_addr : best_idx_q[0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[in_slot] <= {in_z, in_y, in_x};
		end
		if (cmd.rd_en) begin
			rd_data_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cam_load) begin
			cam_x_q <= in_x;
			cam_z_q <= in_z;
		end
	end

	// distance pipeline: read, square, sum
	always_comb begin
		dx = $signed({rd_data_s1[C-1], rd_data_s1[C-1:0]}) - $signed({cam_x_q[C-1], cam_x_q});
		dz = $signed({rd_data_s1[3*C-1], rd_data_s1[3*C-1:2*C]})
			- $signed({cam_z_q[C-1], cam_z_q});
		px = dx * dx;
		pz = dz * dz;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
		end else begin
			vld_s1 <= cmd.scan_vld;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
		end
	end

	always_ff @(posedge clk) begin
		idx_s1  <= scan_addr;
		idx_s2  <= idx_s1;
		idx_s3  <= idx_s2;
		sqx_s2  <= px[SQ_W-1:0];
		sqz_s2  <= pz[SQ_W-1:0];
		dist_s3 <= {1'b0, sqx_s2} + {1'b0, sqz_s2};
	end

	assign sts.pipe_empty = !vld_s1 && !vld_s2 && !vld_s3;

	// slots arrive in ascending order, so an equal distance ranks behind
	// entries already held and strict less-than keeps ties on the lower slot
	always_comb begin
		for (int i = 0; i < MAX_SELECT; i++) begin
			lt[i] = !best_vld_q[i] || (dist_s3 < best_dist_q[i]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_vld_q <= '0;
		end else if (cmd.clear_best) begin
			best_vld_q <= '0;
		end else if (vld_s3) begin
			if (lt[0]) begin
				best_vld_q[0] <= (SEL_W'(0) < sel_count);
			end
			for (int i = 1; i < MAX_SELECT; i++) begin
				if (lt[i] && lt[i-1]) begin
					best_vld_q[i] <= best_vld_q[i-1] && (SEL_W'(i) < sel_count);
				end else if (lt[i]) begin
					best_vld_q[i] <= (SEL_W'(i) < sel_count);
				end
			end
		end else if (cmd.pop_best) begin
			for (int i = 0; i < MAX_SELECT - 1; i++) begin
				best_vld_q[i] <= best_vld_q[i+1];
			end
			best_vld_q[MAX_SELECT-1] <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3 && !cmd.clear_best) begin
			if (lt[0]) begin
				best_dist_q[0] <= dist_s3;
				best_idx_q[0]  <= idx_s3;
			end
			for (int i = 1; i < MAX_SELECT; i++) begin
				if (lt[i] && lt[i-1]) begin
					best_dist_q[i] <= best_dist_q[i-1];
					best_idx_q[i]  <= best_idx_q[i-1];
				end else if (lt[i]) begin
					best_dist_q[i] <= dist_s3;
					best_idx_q[i]  <= idx_s3;
				end
			end
		end else if (cmd.pop_best) begin
			for (int i = 0; i < MAX_SELECT - 1; i++) begin
				best_dist_q[i] <= best_dist_q[i+1];
				best_idx_q[i]  <= best_idx_q[i+1];
			end
		end
	end

	// output register
	assign sts.out_free = !out_vld_q || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_vld_q <= 1'b1;
		end else if (out_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_idx_q  <= best_idx_q[0];
			out_pt_q   <= rd_data_s1;
			out_dist_q <= best_dist_q[0];
			out_last_q <= cmd.out_last;
		end
	end

	assign out_valid = out_vld_q;
	assign out_index = out_idx_q;
	assign out_x     = out_pt_q[C-1:0];
	assign out_y     = out_pt_q[2*C-1:C];
	assign out_z     = out_pt_q[3*C-1:2*C];
	assign out_dist  = out_dist_q;
	assign out_last  = out_last_q;

endmodule

>>> rtl/k_nearest_point_select_unit.sv
// ----------------------------------------------------------------------------
// k_nearest_point_select_unit
// Keeps a table of points and returns the ones nearest a camera in x,z.
// ----------------------------------------------------------------------------
// usage:
//   input stream: tuser = 0 loads a point into a slot, tuser = 1 queries with
//   a camera position; a load only writes its slot and gives no results
//   a query scans slots 0 .. min(light_count, MAX_POINTS)-1 through the single
//   read port of the point memory, one slot per cycle, and keeps a sorted list
//   of the nearest k = min(shadow_count, participating count, MAX_SELECT)
//   output stream: k transfers in ascending squared distance, equal distances
//   in slot order, tlast on the final one; k = 0 gives nothing
//   query sequence: scan of the n slots, drain of the distance pipeline, then
//   a memory read and an output load per result, before the next item is taken
//   the input is not taken while a query is in progress
//   a stalled receiver holds the output register; the sequencer waits for it
//   before loading the next result, and the block takes new input while the
//   final result of a query still waits in the output register
//   reset: control state and config registers return to light_count = 64 and
//   shadow_count = 4; point memory is not cleared, slots must be loaded
//   before a query reaches them
//   config writes belong to idle periods only
// ----------------------------------------------------------------------------
module k_nearest_point_select_unit #(
	parameter int MAX_POINTS = 64,
	parameter int MAX_SELECT = 8,
	parameter int COORD_BITS = 16
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	// slave side
	input  logic                                   s_axis_tvalid,
	output logic                                   s_axis_tready,
	// slot, pos_x, pos_y, pos_z, zero pad
	input  logic [((($clog2(MAX_POINTS) + 3*COORD_BITS) + 7) / 8) * 8 - 1:0] s_axis_tdata,
	// cmd
	input  logic                                   s_axis_tuser,
	// master side
	output logic                                   m_axis_tvalid,
	input  logic                                   m_axis_tready,
	// point_index, point_x, point_y, point_z, sq_distance, zero pad
	output logic [((($clog2(MAX_POINTS) + 5*COORD_BITS + 1) + 7) / 8) * 8 - 1:0] m_axis_tdata,
	output logic                                   m_axis_tlast,
	// configuration write port
	input  logic                                   cfg_we,
	input  logic [knps_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [knps_pkg::CFG_W-1:0]             cfg_wdata
);

	localparam int IDX_W  = $clog2(MAX_POINTS);
	localparam int SEL_W  = $clog2(MAX_SELECT + 1);
	localparam int C      = COORD_BITS;
	localparam int DIST_W = 2 * COORD_BITS + 1;
	localparam int OUT_W  = IDX_W + 3 * C + DIST_W;
	localparam int OUT_DW = ((OUT_W + 7) / 8) * 8;

	knps_pkg::knps_cmd_t   cmd;
	knps_pkg::knps_sts_t   sts;
	logic [IDX_W-1:0]      scan_addr;
	logic [SEL_W-1:0]      sel_count;

	logic [IDX_W-1:0]      out_index;
	logic [C-1:0]          out_x, out_y, out_z;
	logic [DIST_W-1:0]     out_dist;

	// sequencer: config registers, scan and emit counting
	knps_ctrl #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_SELECT(MAX_SELECT)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.in_cmd    (s_axis_tuser),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sts       (sts),
		.cmd       (cmd),
		.scan_addr (scan_addr),
		.sel_count (sel_count)
	);

	// point memory, distance pipeline, best list and output register
	knps_dp #(
		.MAX_POINTS(MAX_POINTS),
		.MAX_SELECT(MAX_SELECT),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.scan_addr (scan_addr),
		.sel_count (sel_count),
		.in_slot   (s_axis_tdata[IDX_W-1:0]),
		.in_x      (s_axis_tdata[IDX_W+C-1:IDX_W]),
		.in_y      (s_axis_tdata[IDX_W+2*C-1:IDX_W+C]),
		.in_z      (s_axis_tdata[IDX_W+3*C-1:IDX_W+2*C]),
		.out_ready (m_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_index (out_index),
		.out_x     (out_x),
		.out_y     (out_y),
		.out_z     (out_z),
		.out_dist  (out_dist),
		.out_last  (m_axis_tlast)
	);

	// result packing, index in the low bits
	assign m_axis_tdata = OUT_DW'({out_dist, out_z, out_y, out_x, out_index});

endmodule

>>> test/k_nearest_point_select_unit_test.sv
// ----------------------------------------------------------------------------
// k_nearest_point_select_unit_test
// Self-checking bench: loads points, queries camera positions and checks each
// returned point against typed results or a local nearest-point predictor,
// over several light/shadow count settings and handshake idling patterns.
// ----------------------------------------------------------------------------
module k_nearest_point_select_unit_test;

	localparam int NUM_SLOTS    = 64;
	localparam int MAX_PICK     = 8;
	localparam int S_W          = 56;
	localparam int M_W          = 88;
	localparam int CYCLE_LIMIT  = 300000;
	localparam int SETTLE_WAIT  = 120;
	localparam int HOLD_CYCLES  = 600;

	// one input transfer: load (slot, x, y, z) or query (camera x, z)
	typedef struct packed {
		logic        cmd;
		logic [5:0]  slot;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
	} point_cmd_t;

	// one output transfer
	typedef struct packed {
		logic [5:0]  idx;
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [32:0] sq_dist;
		logic        last;
	} nearest_point_t;

	// directed row: typed rows take four results from the typed table
	typedef struct packed {
		point_cmd_t item;
		logic       typed;
	} dir_row_t;

	typedef struct packed {
		logic [6:0] lc;
		logic [3:0] sc;
		logic [6:0] tx_pct;
		logic [6:0] rx_pct;
		logic [7:0] items;
	} phase_t;

	// directed part runs with light_count = 4 and shadow_count at reset (4)
	localparam int DIR_ROWS = 17;
	localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
		'{'{knps_pkg::CMD_LOAD,  6'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b0},
		'{'{knps_pkg::CMD_LOAD,  6'd1,  16'h7fff, 16'h1234, 16'h7fff}, 1'b0},
		'{'{knps_pkg::CMD_LOAD,  6'd2,  16'h8000, 16'h8000, 16'h8000}, 1'b0},
		'{'{knps_pkg::CMD_LOAD,  6'd3,  16'h0100, 16'h7fff, 16'h0000}, 1'b0},
		'{'{knps_pkg::CMD_QUERY, 6'd0,  16'h0000, 16'hffff, 16'h0000}, 1'b1},
		'{'{knps_pkg::CMD_QUERY, 6'd63, 16'h8000, 16'h0000, 16'h8000}, 1'b1},
		'{'{knps_pkg::CMD_LOAD,  6'd3,  16'h0000, 16'h0007, 16'h0000}, 1'b0},
		'{'{knps_pkg::CMD_QUERY, 6'd5,  16'h0000, 16'h0000, 16'h0000}, 1'b1},
		'{'{knps_pkg::CMD_QUERY, 6'd0,  16'h7fff, 16'h8000, 16'h7fff}, 1'b1},
		'{'{knps_pkg::CMD_LOAD,  6'd63, 16'h1234, 16'h5678, 16'h9abc}, 1'b0},
		'{'{knps_pkg::CMD_LOAD,  6'd2,  16'hffff, 16'h0001, 16'hfffe}, 1'b0},
		'{'{knps_pkg::CMD_QUERY, 6'd0,  16'h0001, 16'h0000, 16'hffff}, 1'b0},
		'{'{knps_pkg::CMD_LOAD,  6'd1,  16'h8001, 16'h7ffe, 16'h0101}, 1'b0},
		'{'{knps_pkg::CMD_QUERY, 6'd42, 16'h4000, 16'h2222, 16'hc000}, 1'b0},
		'{'{knps_pkg::CMD_QUERY, 6'd0,  16'h8000, 16'h0000, 16'h7fff}, 1'b0},
		'{'{knps_pkg::CMD_LOAD,  6'd0,  16'h00ff, 16'hff00, 16'h0f0f}, 1'b0},
		'{'{knps_pkg::CMD_QUERY, 6'd0,  16'h0000, 16'h0000, 16'h0000}, 1'b0}
	};

	// results of the typed query rows, four each, in order
	localparam nearest_point_t TYPED_RESULTS [16] = '{
		// camera at origin
		'{6'd0, 16'h0000, 16'h0000, 16'h0000, 33'h000000000, 1'b0},
		'{6'd3, 16'h0100, 16'h7fff, 16'h0000, 33'h000010000, 1'b0},
		'{6'd1, 16'h7fff, 16'h1234, 16'h7fff, 33'h07ffe0002, 1'b0},
		'{6'd2, 16'h8000, 16'h8000, 16'h8000, 33'h080000000, 1'b1},
		// camera at most negative corner, farthest point gives the largest distance
		'{6'd2, 16'h8000, 16'h8000, 16'h8000, 33'h000000000, 1'b0},
		'{6'd0, 16'h0000, 16'h0000, 16'h0000, 33'h080000000, 1'b0},
		'{6'd3, 16'h0100, 16'h7fff, 16'h0000, 33'h081010000, 1'b0},
		'{6'd1, 16'h7fff, 16'h1234, 16'h7fff, 33'h1fffc0002, 1'b1},
		// equal distance zero: lower slot first
		'{6'd0, 16'h0000, 16'h0000, 16'h0000, 33'h000000000, 1'b0},
		'{6'd3, 16'h0000, 16'h0007, 16'h0000, 33'h000000000, 1'b0},
		'{6'd1, 16'h7fff, 16'h1234, 16'h7fff, 33'h07ffe0002, 1'b0},
		'{6'd2, 16'h8000, 16'h8000, 16'h8000, 33'h080000000, 1'b1},
		// camera at most positive corner, tie between slots 0 and 3
		'{6'd1, 16'h7fff, 16'h1234, 16'h7fff, 33'h000000000, 1'b0},
		'{6'd0, 16'h0000, 16'h0000, 16'h0000, 33'h07ffe0002, 1'b0},
		'{6'd3, 16'h0000, 16'h0007, 16'h0000, 33'h07ffe0002, 1'b0},
		'{6'd2, 16'h8000, 16'h8000, 16'h8000, 33'h1fffc0002, 1'b1}
	};

	// random phases: counts including their extremes, idling patterns in turn
	localparam int NUM_PHASES = 7;
	localparam phase_t PHASES [NUM_PHASES] = '{
		'{7'd64,  4'd8,  7'd0,  7'd0,  8'd8},
		'{7'd1,   4'd15, 7'd70, 7'd0,  8'd6},
		'{7'd127, 4'd3,  7'd0,  7'd70, 8'd8},
		'{7'd0,   4'd5,  7'd24, 7'd24, 8'd4},
		'{7'd20,  4'd0,  7'd70, 7'd0,  8'd4},
		'{7'd10,  4'd8,  7'd24, 7'd24, 8'd6},
		'{7'd64,  4'd2,  7'd0,  7'd70, 8'd6}
	};

	logic                           clk;
	logic                           arst_n;
	logic                           s_axis_tvalid;
	logic                           s_axis_tready;
	// slot, pos_x, pos_y, pos_z, zero pad
	logic [S_W-1:0]                 s_axis_tdata;
	// cmd
	logic                           s_axis_tuser;
	logic                           m_axis_tvalid;
	logic                           m_axis_tready;
	// point_index, point_x, point_y, point_z, sq_distance, zero pad
	logic [M_W-1:0]                 m_axis_tdata;
	logic                           m_axis_tlast;
	logic                           cfg_we;
	logic [knps_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [knps_pkg::CFG_W-1:0]     cfg_wdata;

	// predictor state: point table and counts as the block should hold them
	logic [15:0]                    slot_x [NUM_SLOTS];
	logic [15:0]                    slot_y [NUM_SLOTS];
	logic [15:0]                    slot_z [NUM_SLOTS];
	logic [knps_pkg::LC_W-1:0]      light_cfg;
	logic [knps_pkg::SC_W-1:0]      shadow_cfg;

	// nearest points still owed by the block, oldest first
	nearest_point_t                 nearest_q [$];

	int                             fail_count;
	int                             cycle_count;
	int                             typed_ptr;
	int                             tx_idle_pct;
	int                             rx_stall_pct;
	int                             hold_request;

	k_nearest_point_select_unit uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// predictor: scan slots 0 .. n-1, keep the k nearest in a sorted list,
	// equal distances keep scan order so the lower slot wins
	function automatic void queue_nearest(input logic [15:0] cam_x, input logic [15:0] cam_z);
		int             n;
		int             k;
		int             cnt;
		int             p;
		int             e;
		longint         dx;
		longint         dz;
		longint         sq;
		logic [32:0]    d;
		logic [32:0]    best_d [MAX_PICK];
		int             best_s [MAX_PICK];
		nearest_point_t r;
		n = (light_cfg > NUM_SLOTS) ? NUM_SLOTS : int'(light_cfg);
		k = int'(shadow_cfg);
		if (k > n)
			k = n;
		if (k > MAX_PICK)
			k = MAX_PICK;
		cnt = 0;
		if (k > 0) begin
			for (int s = 0; s < n; s++) begin
				dx = longint'($signed(slot_x[s])) - longint'($signed(cam_x));
				dz = longint'($signed(slot_z[s])) - longint'($signed(cam_z));
				sq = dx * dx + dz * dz;
				d = sq[32:0];
				p = cnt;
				while (p > 0 && d < best_d[p-1])
					p--;
				if (p < k) begin
					e = (cnt < k) ? cnt : k - 1;
					while (e > p) begin
						best_d[e] = best_d[e-1];
						best_s[e] = best_s[e-1];
						e--;
					end
					best_d[p] = d;
					best_s[p] = s;
					if (cnt < k)
						cnt++;
				end
			end
		end
		for (int i = 0; i < cnt; i++) begin
			r.idx     = 6'(best_s[i]);
			r.x       = slot_x[best_s[i]];
			r.y       = slot_y[best_s[i]];
			r.z       = slot_z[best_s[i]];
			r.sq_dist = best_d[i];
			r.last    = (i == cnt - 1);
			nearest_q.insert(nearest_q.size(), r);
		end
	endfunction

	// signed Q8.8 value, biased toward the extremes and toward tiny values
	// so that equal distances show up
	function automatic logic [15:0] random_coord();
		unique case ($urandom_range(0, 9))
			0: return 16'h8000;
			1: return 16'h7fff;
			2, 3: return 16'(int'($urandom_range(0, 6)) - 3);
			default: return 16'($urandom);
		endcase
	endfunction

	function automatic point_cmd_t random_item(input int query_pct);
		point_cmd_t it;
		it.cmd  = ($urandom_range(0, 99) < query_pct) ? knps_pkg::CMD_QUERY : knps_pkg::CMD_LOAD;
		it.slot = 6'($urandom_range(0, NUM_SLOTS - 1));
		it.x    = random_coord();
		it.y    = random_coord();
		it.z    = random_coord();
		return it;
	endfunction

	// entered and left at a falling edge; on acceptance a load updates the table,
	// a query runs the predictor, or the typed results of a directed row are queued
	task automatic send_item(input point_cmd_t it, input logic typed);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid = 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid = 1'b1;
		s_axis_tuser  = it.cmd;
		s_axis_tdata  = {2'b00, it.z, it.y, it.x, it.slot};
		do
			@(posedge clk);
		while (!s_axis_tready);
		if (it.cmd == knps_pkg::CMD_LOAD) begin
			slot_x[it.slot] = it.x;
			slot_y[it.slot] = it.y;
			slot_z[it.slot] = it.z;
		end else if (typed) begin
			for (int i = 0; i < 4; i++)
				nearest_q.insert(nearest_q.size(), TYPED_RESULTS[typed_ptr + i]);
			typed_ptr += 4;
		end else begin
			queue_nearest(it.x, it.z);
		end
		@(negedge clk);
	endtask

	task automatic write_reg(input logic [knps_pkg::CFG_IDX_W-1:0] idx,
			input logic [knps_pkg::CFG_W-1:0] val);
		cfg_we    = 1'b1;
		cfg_index = idx;
		cfg_wdata = val;
		@(posedge clk);
		if (idx == knps_pkg::REG_LIGHT_COUNT)
			light_cfg = val[knps_pkg::LC_W-1:0];
		else
			shadow_cfg = val[knps_pkg::SC_W-1:0];
		@(negedge clk);
		cfg_we = 1'b0;
	endtask

	// all owed results in, then a settle wait for a query that returns nothing
	task automatic wait_drained();
		s_axis_tvalid = 1'b0;
		while (nearest_q.size() != 0)
			@(negedge clk);
		repeat (SETTLE_WAIT) @(negedge clk);
	endtask

	task automatic check_field(input string name, input logic [32:0] want,
			input logic [32:0] got);
		if (got !== want) begin
			fail_count++;
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
		end
	endtask

	// receiver: random stalls, or a long hold-off on request
	initial begin : receiver
		int hold_left;
		hold_left     = 0;
		m_axis_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request > 0) begin
				hold_left    = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				m_axis_tready = 1'b0;
				hold_left--;
			end else begin
				m_axis_tready = ($urandom_range(0, 99) >= rx_stall_pct);
			end
		end
	end

	// output transfers checked against the oldest owed result
	always @(posedge clk) begin : result_check
		nearest_point_t got;
		nearest_point_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.idx     = m_axis_tdata[5:0];
			got.x       = m_axis_tdata[21:6];
			got.y       = m_axis_tdata[37:22];
			got.z       = m_axis_tdata[53:38];
			got.sq_dist = m_axis_tdata[86:54];
			got.last    = m_axis_tlast;
			if (nearest_q.size() == 0) begin
				fail_count++;
				$display("%0t: unexpected result, expected none actual %h", $time, got);
			end else begin
				want = nearest_q.pop_front();
				check_field("point_index", 33'(want.idx), 33'(got.idx));
				check_field("point_x", 33'(want.x), 33'(got.x));
				check_field("point_y", 33'(want.y), 33'(got.y));
				check_field("point_z", 33'(want.z), 33'(got.z));
				check_field("sq_distance", want.sq_dist, got.sq_dist);
				check_field("last", 33'(want.last), 33'(got.last));
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("k_nearest_point_select_unit_test: errors");
			$finish;
		end
	end

	initial begin : stimulus
		point_cmd_t it;
		arst_n        = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata  = '0;
		s_axis_tuser  = 1'b0;
		cfg_we        = 1'b0;
		cfg_index     = knps_pkg::REG_LIGHT_COUNT;
		cfg_wdata     = '0;
		light_cfg     = knps_pkg::LIGHT_COUNT_RST;
		shadow_cfg    = knps_pkg::SHADOW_COUNT_RST;
		fail_count    = 0;
		cycle_count   = 0;
		typed_ptr     = 0;
		tx_idle_pct   = 0;
		rx_stall_pct  = 0;
		hold_request  = 0;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// only slots 0..3 are loaded yet, so keep the scan within them
		write_reg(knps_pkg::REG_LIGHT_COUNT, 7'd4);
		for (int r = 0; r < DIR_ROWS; r++)
			send_item(DIR_TABLE[r].item, DIR_TABLE[r].typed);
		wait_drained();

		// fill the rest of the table before any wide scan
		tx_idle_pct = 24;
		for (int s = 4; s < NUM_SLOTS; s++) begin
			it      = random_item(0);
			it.slot = 6'(s);
			send_item(it, 1'b0);
		end

		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_drained();
			write_reg(knps_pkg::REG_LIGHT_COUNT, PHASES[ph].lc);
			// upper data bits are don't-care for the 4-bit register
			write_reg(knps_pkg::REG_SHADOW_COUNT, {3'($urandom), PHASES[ph].sc});
			tx_idle_pct  = PHASES[ph].tx_pct;
			rx_stall_pct = PHASES[ph].rx_pct;
			for (int i = 0; i < PHASES[ph].items; i++)
				send_item(random_item(45), 1'b0);
		end

		// back-pressure: receiver holds off while queries keep coming, so the
		// output register fills and the input stalls
		wait_drained();
		write_reg(knps_pkg::REG_LIGHT_COUNT, 7'd64);
		write_reg(knps_pkg::REG_SHADOW_COUNT, {3'($urandom), 4'd8});
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		hold_request = HOLD_CYCLES;
		for (int i = 0; i < 6; i++)
			send_item(random_item(100), 1'b0);

		wait_drained();
		if (fail_count == 0)
			$display("k_nearest_point_select_unit_test: clean");
		else
			$display("k_nearest_point_select_unit_test: errors");
		$finish;
	end

endmodule
